### hw/rtl/cks_pkg.sv
// ----------------------------------------------------------------------------
// cks_pkg
// shared types and constants of the two-table cuckoo insert block with stash
// ----------------------------------------------------------------------------
package cks_pkg;

    localparam int TABLE_DEPTH  = 4096;
    localparam int TABLE_ADDR_W = $clog2(TABLE_DEPTH);
    localparam int STASH_DEPTH  = 16;
    localparam int STASH_IDX_W  = $clog2(STASH_DEPTH);
    localparam int STASH_CNT_W  = $clog2(STASH_DEPTH + 1);
    localparam int INDEX_BITS   = 20;
    localparam int HASH_W       = 64;
    localparam int BINS_W       = 13;
    localparam int EVICT_W      = 16;

    localparam logic [BINS_W-1:0]  BINS_RESET  = BINS_W'(TABLE_DEPTH);
    localparam logic [EVICT_W-1:0] EVICT_RESET = EVICT_W'(4096);

    // modes
    localparam logic [1:0] MODE_INSERT     = 2'd0;
    localparam logic [1:0] MODE_READ_TABLE = 2'd1;
    localparam logic [1:0] MODE_READ_STASH = 2'd2;

    // result codes
    localparam logic [2:0] ST_PLACED  = 3'd0;
    localparam logic [2:0] ST_STASHED = 3'd1;
    localparam logic [2:0] ST_DROPPED = 3'd2;
    localparam logic [2:0] ST_RD_VAL  = 3'd3;
    localparam logic [2:0] ST_RD_EMP  = 3'd4;

    // register indexes
    localparam logic REG_BINS  = 1'b0;
    localparam logic REG_EVICT = 1'b1;

    typedef struct packed {
        logic [1:0]              mode;
        logic [INDEX_BITS-1:0]   item_index;
        logic [HASH_W-1:0]       hash0;
        logic [HASH_W-1:0]       hash1;
        logic                    read_table;
        logic [TABLE_ADDR_W-1:0] read_slot;
    } t_in;

    typedef struct packed {
        logic [2:0]              status;
        logic                    table_sel;
        logic [TABLE_ADDR_W-1:0] slot;
        logic [EVICT_W-1:0]      evictions;
        logic [INDEX_BITS-1:0]   item_out;
        logic [STASH_CNT_W-1:0]  stash_used;
    } t_out;

    typedef struct packed {
        logic                    valid;
        logic [INDEX_BITS-1:0]   item;
        logic [TABLE_ADDR_W-1:0] alt_bin;
    } t_entry;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic eval;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic again;
    } t_dp_st;

endpackage

### hw/rtl/cks_mod.sv
// ----------------------------------------------------------------------------
// cks_mod
// bit-serial remainder of a 64-bit hash by the bin count, one bit a cycle
// ----------------------------------------------------------------------------
module cks_mod
    import cks_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [HASH_W-1:0]       i_dividend,
    input  logic [BINS_W-1:0]       i_divisor,
    output logic [TABLE_ADDR_W-1:0] o_rem,
    output logic                    o_done
);

    localparam int CNT_W = $clog2(HASH_W);

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [HASH_W-1:0]       r_shift;
    logic [TABLE_ADDR_W-1:0] r_rem;
    logic [BINS_W-1:0]       w_trial;
    logic [TABLE_ADDR_W-1:0] n_rem;

    // remainder stays below the divisor, so the trial is under twice it
    always_comb begin
        w_trial = {r_rem, r_shift[HASH_W-1]};
        if (w_trial >= i_divisor) begin
            n_rem = TABLE_ADDR_W'(w_trial - i_divisor);
        end else begin
            n_rem = TABLE_ADDR_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(HASH_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_dividend;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[HASH_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule

### hw/rtl/cks_dp.sv
// ----------------------------------------------------------------------------
// cks_dp
// datapath: bin tables, stash, eviction registers and result register
// ----------------------------------------------------------------------------
module cks_dp
    import cks_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  t_in                 i_item,
    input  logic [BINS_W-1:0]   i_bins,
    input  logic [EVICT_W-1:0]  i_max_ev,
    output t_dp_st              o_st,
    output t_out                o_res,
    output logic                o_done
);

    t_entry r_mem0 [TABLE_DEPTH];
    t_entry r_mem1 [TABLE_DEPTH];
    t_entry r_rd0;
    t_entry r_rd1;

    logic [INDEX_BITS-1:0]   r_stash [STASH_DEPTH];
    logic [STASH_CNT_W-1:0]  r_scount;
    logic [TABLE_ADDR_W-1:0] r_clr_addr;

    logic [1:0]              r_mode;
    logic [INDEX_BITS-1:0]   r_carry;
    logic [TABLE_ADDR_W-1:0] r_addr;
    logic [TABLE_ADDR_W-1:0] r_alt;
    logic                    r_t;
    logic                    r_oih;
    logic                    r_ot;
    logic [TABLE_ADDR_W-1:0] r_oa;
    logic [EVICT_W-1:0]      r_tries;
    logic                    r_rtab;
    logic [TABLE_ADDR_W-1:0] r_rslot;
    t_out                    r_res;
    logic                    r_done;

    logic [TABLE_ADDR_W-1:0] w_rem0;
    logic [TABLE_ADDR_W-1:0] w_rem1;
    logic                    w_mdone0;
    logic                    w_mdone1;
    logic                    w_mstart;

    t_entry                  w_cur;
    t_entry                  w_new;
    t_entry                  w_wd;
    logic                    w_ins;
    logic                    w_occ;
    logic                    w_can_ev;
    logic                    w_tbl_wr;
    logic                    w_we0;
    logic                    w_we1;
    logic                    w_stash_wr;
    logic [TABLE_ADDR_W-1:0] w_wa;
    logic [TABLE_ADDR_W-1:0] w_ra;
    t_out                    n_res;

    assign w_mstart = i_cmd.load && (i_item.mode == MODE_INSERT);

    cks_mod u_mod0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mstart),
        .i_dividend(i_item.hash0),
        .i_divisor (i_bins),
        .o_rem     (w_rem0),
        .o_done    (w_mdone0)
    );

    cks_mod u_mod1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mstart),
        .i_dividend(i_item.hash1),
        .i_divisor (i_bins),
        .o_rem     (w_rem1),
        .o_done    (w_mdone1)
    );

    always_comb begin
        w_ins    = (r_mode == MODE_INSERT);
        w_cur    = r_t ? r_rd1 : r_rd0;
        w_occ    = w_cur.valid;
        w_can_ev = (r_tries < i_max_ev);
        w_new    = '{valid: 1'b1, item: r_carry, alt_bin: r_alt};
        w_tbl_wr = i_cmd.eval && w_ins && (!w_occ || w_can_ev);
        w_we0    = i_cmd.clr || (w_tbl_wr && !r_t);
        w_we1    = i_cmd.clr || (w_tbl_wr && r_t);
        w_wa     = i_cmd.clr ? r_clr_addr : r_addr;
        w_wd     = i_cmd.clr ? t_entry'('0) : w_new;
        w_ra     = (r_mode == MODE_READ_TABLE) ? r_rslot : r_addr;
        w_stash_wr = i_cmd.eval && w_ins && w_occ && !w_can_ev
                     && (r_scount < STASH_CNT_W'(STASH_DEPTH));
    end

    always_comb begin
        n_res            = '0;
        n_res.status     = ST_RD_EMP;
        n_res.stash_used = r_scount;
        case (r_mode)
            MODE_INSERT: begin
                n_res.evictions = r_tries;
                if (!w_occ) begin
                    n_res.status    = ST_PLACED;
                    n_res.table_sel = r_oih ? r_t : r_ot;
                    n_res.slot      = r_oih ? r_addr : r_oa;
                end else if (r_scount < STASH_CNT_W'(STASH_DEPTH)) begin
                    n_res.status     = ST_STASHED;
                    n_res.slot       = TABLE_ADDR_W'(r_scount);
                    n_res.stash_used = r_scount + 1'b1;
                end else begin
                    n_res.status = ST_DROPPED;
                end
            end
            MODE_READ_TABLE: begin
                n_res.table_sel = r_rtab;
                n_res.slot      = r_rslot;
                if (r_rtab ? r_rd1.valid : r_rd0.valid) begin
                    n_res.status   = ST_RD_VAL;
                    n_res.item_out = r_rtab ? r_rd1.item : r_rd0.item;
                end
            end
            MODE_READ_STASH: begin
                n_res.slot = r_rslot;
                if (r_rslot < TABLE_ADDR_W'(r_scount)) begin
                    n_res.status   = ST_RD_VAL;
                    n_res.item_out = r_stash[r_rslot[STASH_IDX_W-1:0]];
                end
            end
            default: begin
                n_res.status = ST_RD_EMP;
            end
        endcase
    end

    // table memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_we0) begin
            r_mem0[w_wa] <= w_wd;
        end
        if (i_cmd.rd) begin
            r_rd0 <= r_mem0[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we1) begin
            r_mem1[w_wa] <= w_wd;
        end
        if (i_cmd.rd) begin
            r_rd1 <= r_mem1[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_stash_wr) begin
            r_stash[r_scount[STASH_IDX_W-1:0]] <= r_carry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scount   <= '0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_stash_wr) begin
                r_scount <= r_scount + 1'b1;
            end
            if (i_cmd.eval && !o_st.again) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_item.mode;
            r_carry <= i_item.item_index;
            r_rtab  <= i_item.read_table;
            r_rslot <= i_item.read_slot;
            r_t     <= 1'b0;
            r_oih   <= 1'b1;
            r_tries <= '0;
        end else if (w_mdone0) begin
            r_addr <= w_rem0;
            r_alt  <= w_rem1;
        end else if (i_cmd.eval) begin
            if (o_st.again) begin
                // evict the occupant and carry it to its bin in the other table
                r_carry <= w_cur.item;
                r_alt   <= r_addr;
                r_addr  <= w_cur.alt_bin;
                r_t     <= ~r_t;
                r_tries <= r_tries + 1'b1;
                if (r_oih) begin
                    r_oih <= 1'b0;
                    r_ot  <= r_t;
                    r_oa  <= r_addr;
                end else if (r_ot == r_t && r_oa == r_addr) begin
                    r_oih <= 1'b1;
                end
            end else begin
                r_res <= n_res;
            end
        end
    end

    assign o_st.clr_last = (r_clr_addr == TABLE_ADDR_W'(TABLE_DEPTH - 1));
    assign o_st.mod_done = w_mdone0 && w_mdone1;
    assign o_st.again    = w_ins && w_occ && w_can_ev;
    assign o_res         = r_res;
    assign o_done        = r_done;

endmodule

### hw/rtl/cks_ctrl.sv
// ----------------------------------------------------------------------------
// cks_ctrl
// controller: clearing pass, hash reduction wait, read/evaluate loop
// ----------------------------------------------------------------------------
module cks_ctrl
    import cks_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_dp_st     i_st,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_READ,
        S_EVAL
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_comb begin
        o_cmd      = '0;
        o_cmd.clr  = (r_state == S_CLEAR);
        o_cmd.load = (r_state == S_IDLE) && i_start;
        o_cmd.rd   = (r_state == S_READ);
        o_cmd.eval = (r_state == S_EVAL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_st.clr_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_busy <= 1'b1;
                        if (i_mode == MODE_INSERT) begin
                            r_state <= S_MOD;
                        end else if (i_mode == MODE_READ_TABLE) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_MOD: begin
                    if (i_st.mod_done) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!i_st.again) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end else begin
                        r_state <= S_READ;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_busy = r_busy;

endmodule

### hw/rtl/cuckoo_hash_insert_with_stash_top.sv
// ----------------------------------------------------------------------------
// cuckoo_hash_insert_with_stash_top
// two-table cuckoo insert with stash, table and stash readback, apb config
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over both tables with busy
// high. For an insert the result strobe comes after the bit-serial
// reduction of both hashes and the loading of the bins, then one table read
// and one evaluate/write per bin visited. A table read passes through the
// read state and then the evaluate state; a stash read or an unused mode 3
// goes through the evaluate state alone. The result is shown for one cycle
// on o_done and cannot be held off; start is taken when busy is low, which
// is already the case in the strobe cycle.
module cuckoo_hash_insert_with_stash_top
    import cks_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in         i_cmd,
    output t_out        o_res,
    output logic        o_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [BINS_W-1:0]  r_bins;
    logic [EVICT_W-1:0] r_max_ev;
    logic [BINS_W-1:0]  w_bins_use;
    t_dp_cmd            w_cmd;
    t_dp_st             w_st;
    logic               w_wr;

    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bins   <= BINS_RESET;
            r_max_ev <= EVICT_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_BINS) begin
                r_bins <= pwdata[BINS_W-1:0];
            end else begin
                r_max_ev <= pwdata[EVICT_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_EVICT) ? {16'b0, r_max_ev} : {19'b0, r_bins};

    // zero bins means one, above the table depth means the depth
    always_comb begin
        if (r_bins == '0) begin
            w_bins_use = BINS_W'(1);
        end else if (r_bins > BINS_W'(TABLE_DEPTH)) begin
            w_bins_use = BINS_W'(TABLE_DEPTH);
        end else begin
            w_bins_use = r_bins;
        end
    end

    cks_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_mode (i_cmd.mode),
        .i_st   (w_st),
        .o_cmd  (w_cmd),
        .o_busy (busy)
    );

    cks_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_item  (i_cmd),
        .i_bins  (w_bins_use),
        .i_max_ev(r_max_ev),
        .o_st    (w_st),
        .o_res   (o_res),
        .o_done  (o_done)
    );

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without work in progress");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_stash_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_res.stash_used <= STASH_CNT_W'(STASH_DEPTH)))
        else $error("stash count beyond depth");
`endif

endmodule
